// ----- rtl/protection_code_parser_top_defines.svh -----
// Assertion macros for the protection code parser.
// Used by protection_code_parser_top.sv; relies on clk and arst_n in the including module.
`ifndef PROTECTION_CODE_PARSER_TOP_DEFINES_SVH
`define PROTECTION_CODE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pcp_pkg.sv -----
// Package for the protection code parser: parse phase codes, character codes
// and small helper functions. No dependencies.
`default_nettype none

package pcp_pkg;

	localparam int PhaseW = 3;

	localparam logic [PhaseW-1:0] PH_START  = 3'd0;
	localparam logic [PhaseW-1:0] PH_SEP    = 3'd1;
	localparam logic [PhaseW-1:0] PH_CAT    = 3'd2;
	localparam logic [PhaseW-1:0] PH_ACCESS = 3'd3;
	localparam logic [PhaseW-1:0] PH_SKIP   = 3'd4;
	localparam logic [PhaseW-1:0] PH_DONE   = 3'd5;

	localparam logic [3:0] GROUP_MASK = 4'hF;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UP_D   = 8'h44;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_G   = 8'h47;
	localparam logic [7:0] CH_UP_O   = 8'h4F;
	localparam logic [7:0] CH_UP_R   = 8'h52;
	localparam logic [7:0] CH_UP_S   = 8'h53;
	localparam logic [7:0] CH_UP_W   = 8'h57;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CASE_DIFF = 8'h20;

	localparam logic [1:0] CAT_SYSTEM = 2'd0;
	localparam logic [1:0] CAT_OWNER  = 2'd1;
	localparam logic [1:0] CAT_GROUP  = 2'd2;
	localparam logic [1:0] CAT_WORLD  = 2'd3;

	// Folds lower-case ASCII letters onto upper case.
	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			u = c - CASE_DIFF;
		end
		return u;
	endfunction

	// Replaces the 4-bit group picked by sel with bits.
	function automatic logic [15:0] merge_group(input logic [15:0] word,
			input logic [1:0] sel, input logic [3:0] bits);
		logic [3:0] sh;
		sh = {sel, 2'b00};
		return (word & ~({12'h000, GROUP_MASK} << sh)) | ({12'h000, bits} << sh);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/protection_code_parser_top.sv -----
// Protection code parser: one input stage register, the parse state and a result register.
// Depends on pcp_pkg and protection_code_parser_top_defines.svh.
// The result register loads as a staged request carrying last leaves the input stage.
// Throughput: one request per cycle; the input stage stalls only while a finished result
// waits unaccepted in the output register and the staged request carries last.
// Reset (arst_n low, asynchronous): stages empty, parse at start, word zero, group all denied.
`default_nettype none

`include "protection_code_parser_top_defines.svh"

module protection_code_parser_top
	import pcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        first,
	input  wire logic [15:0] base_prot,
	input  wire logic [7:0]  char_code,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      prot_word
);

	// Input stage: the request as accepted.
	logic        valid_s1;
	logic        first_s1;
	logic [15:0] base_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// Parse state carried from one byte to the next.
	logic [PhaseW-1:0] phase_q;
	logic [15:0]       merged_q;
	logic [3:0]        pending_q;
	logic [1:0]        cat_q;

	// Result register.
	logic        out_valid_q;
	logic [15:0] prot_q;

	// The staged byte is consumed unless it would produce a result while the
	// output register is still full and not being emptied.
	logic advance;
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Parse step for the staged byte.
	logic [PhaseW-1:0] ph_cur, ph_nxt;
	logic [15:0]       mw_cur, mw_nxt;
	logic [3:0]        pb_cur, pb_nxt;
	logic [1:0]        cs_cur, cs_nxt;
	logic [7:0]        up;
	logic              is_sep, is_end, is_cat;
	logic [1:0]        cat_code;
	logic [3:0]        acc_clr;
	logic [15:0]       result;

	always_comb begin
		// A first byte restarts the parse from the base word.
		ph_cur = first_s1 ? PH_START : phase_q;
		mw_cur = first_s1 ? base_s1 : merged_q;
		pb_cur = first_s1 ? GROUP_MASK : pending_q;
		cs_cur = first_s1 ? CAT_SYSTEM : cat_q;

		up     = to_upper(char_s1);
		is_sep = (char_s1 == CH_SPACE) || (char_s1 == CH_COMMA) || (char_s1 == CH_TAB);
		is_end = (char_s1 == CH_NUL) || (char_s1 == CH_RPAREN);
		is_cat = (up == CH_UP_S) || (up == CH_UP_O) || (up == CH_UP_G) || (up == CH_UP_W);

		priority if (up == CH_UP_S) begin
			cat_code = CAT_SYSTEM;
		end else if (up == CH_UP_O) begin
			cat_code = CAT_OWNER;
		end else if (up == CH_UP_G) begin
			cat_code = CAT_GROUP;
		end else begin
			cat_code = CAT_WORLD;
		end

		// Access letters clear their deny bit; anything else clears nothing.
		priority if (up == CH_UP_R) begin
			acc_clr = 4'b0001;
		end else if (up == CH_UP_W) begin
			acc_clr = 4'b0010;
		end else if (up == CH_UP_E) begin
			acc_clr = 4'b0100;
		end else if (up == CH_UP_D) begin
			acc_clr = 4'b1000;
		end else begin
			acc_clr = 4'b0000;
		end

		ph_nxt = ph_cur;
		mw_nxt = mw_cur;
		pb_nxt = pb_cur;
		cs_nxt = cs_cur;

		unique case (ph_cur)
			PH_START, PH_SEP: begin
				// A leading parenthesis is skipped only as the very first byte.
				priority if (ph_cur == PH_START && char_s1 == CH_LPAREN) begin
					ph_nxt = PH_SEP;
				end else if (is_sep) begin
					ph_nxt = PH_SEP;
				end else if (is_end) begin
					ph_nxt = PH_DONE;
				end else if (is_cat) begin
					cs_nxt = cat_code;
					pb_nxt = GROUP_MASK;
					ph_nxt = PH_CAT;
				end else begin
					ph_nxt = PH_SKIP;
				end
			end
			PH_CAT, PH_ACCESS: begin
				// A colon right after the category letter is optional.
				priority if (ph_cur == PH_CAT && char_s1 == CH_COLON) begin
					ph_nxt = PH_ACCESS;
				end else if (is_end || char_s1 == CH_COMMA || char_s1 == CH_SPACE) begin
					mw_nxt = merge_group(mw_cur, cs_cur, pb_cur);
					ph_nxt = is_end ? PH_DONE : PH_SEP;
				end else begin
					pb_nxt = pb_cur & ~acc_clr;
					ph_nxt = PH_ACCESS;
				end
			end
			PH_SKIP: begin
				// Unknown category text runs to a comma or the end of the text.
				priority if (is_end) begin
					ph_nxt = PH_DONE;
				end else if (char_s1 == CH_COMMA) begin
					ph_nxt = PH_SEP;
				end else begin
					ph_nxt = PH_SKIP;
				end
			end
			default: begin
				ph_nxt = PH_DONE;
			end
		endcase

		// An unterminated category is folded into the result.
		if (ph_nxt == PH_CAT || ph_nxt == PH_ACCESS) begin
			result = merge_group(mw_nxt, cs_nxt, pb_nxt);
		end else begin
			result = mw_nxt;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			first_s1 <= first;
			base_s1  <= base_prot;
			char_s1  <= char_code;
			last_s1  <= last;
		end
	end

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			merged_q  <= 16'h0000;
			pending_q <= GROUP_MASK;
			cat_q     <= CAT_SYSTEM;
		end else if (advance) begin
			phase_q   <= ph_nxt;
			merged_q  <= mw_nxt;
			pending_q <= pb_nxt;
			cat_q     <= cs_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			prot_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign prot_word = prot_q;

	`PCP_ASSERT_NEXT(a_last_gives_result, advance && last_s1, out_valid_q,
		"a last byte did not produce a result")
	`PCP_ASSERT_NOW(a_stall_blocks_input, valid_s1 && !advance, !in_ready,
		"input accepted while the staged byte is stalled")
	`PCP_ASSERT_NEXT(a_done_holds_word, advance && !first_s1 && phase_q == PH_DONE,
		$stable(merged_q) && phase_q == PH_DONE, "parse state changed after the end of text")
	`PCP_ASSERT_NEXT(a_first_paren, advance && first_s1 && char_s1 == CH_LPAREN,
		phase_q == PH_SEP && merged_q == $past(base_s1), "leading parenthesis mishandled")

endmodule

`default_nettype wire

// ----- tb/tb_protection_code_parser_top.sv -----
`timescale 1ns / 100ps
// Testbench for protection_code_parser_top: directed table plus random protection strings,
// checked against an in-bench parse model. Depends on pcp_pkg and the RTL top level.

module tb_protection_code_parser_top
	import pcp_pkg::*;
;

	// Access bit positions inside one 4-bit category group.
	localparam int ACC_READ = 0;
	localparam int ACC_WRITE = 1;
	localparam int ACC_EXEC = 2;
	localparam int ACC_DELETE = 3;

	localparam int ITEM_TARGET = 1550;
	localparam int PAUSE_AT = 800;
	localparam int QUIET_AT = 1300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic first = 1'b0;
	logic [15:0] base_prot = 16'h0000;
	logic [7:0] char_code = 8'h00;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] prot_word;

	protection_code_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.first     (first),
		.base_prot (base_prot),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.prot_word (prot_word)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// One request as the sender presents it.
	typedef struct {
		logic        f;
		logic [15:0] base;
		logic [7:0]  ch;
		logic        l;
	} req_t;

	// One row of the directed table. When typed is set, want is the result read straight
	// off the parse rules; otherwise the parse model supplies the expected word.
	typedef struct packed {
		logic        f;
		logic [15:0] base;
		logic [7:0]  ch;
		logic        l;
		logic        typed;
		logic [15:0] want;
	} dir_row_t;

	localparam int DIR_ROWS = 26;

	// The table walks through one full S group with every access letter in mixed case,
	// an owner group with an unknown letter, a tab and a colon inside the list, bytes
	// after the parse has ended, a leading parenthesis, a parenthesis as unknown category
	// text, an unterminated world group, a continuation without a first flag, an
	// immediate close, a zero byte ending a group, and a skip closed by a parenthesis.
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{1'b0, 16'h0000, CH_NUL,    1'b1, 1'b1, 16'h0000},
		'{1'b1, 16'hFFFF, CH_UP_S,   1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_COLON,  1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_UP_R,   1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, "w",       1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_UP_E,   1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, "d",       1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_COMMA,  1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, "o",       1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, "x",       1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_TAB,    1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_COLON,  1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_RPAREN, 1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_UP_G,   1'b1, 1'b1, 16'hFFF0},
		'{1'b1, 16'h0000, CH_LPAREN, 1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_LPAREN, 1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_SPACE,  1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_COMMA,  1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_UP_W,   1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_UP_R,   1'b1, 1'b1, 16'hE000},
		'{1'b0, 16'hFFFF, CH_SPACE,  1'b1, 1'b0, 16'h0000},
		'{1'b1, 16'h1234, CH_RPAREN, 1'b1, 1'b1, 16'h1234},
		'{1'b1, 16'hA5A5, "g",       1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_NUL,    1'b1, 1'b1, 16'hAFA5},
		'{1'b1, 16'h0F0F, 8'hFF,     1'b0, 1'b0, 16'h0000},
		'{1'b0, 16'h0000, CH_RPAREN, 1'b1, 1'b1, 16'h0F0F}
	};

	// Parse model state: position in the text, word built so far, group being read and
	// the category it belongs to.
	logic [PhaseW-1:0] ps_phase = PH_START;
	logic [15:0] ps_word = 16'h0000;
	logic [3:0] ps_group = GROUP_MASK;
	logic [1:0] ps_cat = CAT_SYSTEM;

	logic [15:0] expected_words [$];
	logic [7:0] text_q [$];
	int err_cnt = 0;
	int sent_cnt = 0;
	bit quiet_mode = 1'b0;
	int stall_left = 0;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			return c - CASE_DIFF;
		end
		return c;
	endfunction

	// The word as it would stand if the group being read were closed now.
	function automatic logic [15:0] word_with_group();
		logic [15:0] w;
		w = ps_word;
		w[ps_cat*4 +: 4] = ps_group;
		return w;
	endfunction

	// A byte between categories: separators are skipped, a category letter opens a group,
	// a close or zero ends the parse, and anything else starts a skip to the next comma.
	task automatic between_cats(input logic [7:0] c);
		logic [7:0] u;
		u = fold_case(c);
		if (c == CH_SPACE || c == CH_COMMA || c == CH_TAB) begin
			return;
		end
		if (c == CH_NUL || c == CH_RPAREN) begin
			ps_phase = PH_DONE;
		end else if (u == CH_UP_S || u == CH_UP_O || u == CH_UP_G || u == CH_UP_W) begin
			case (u)
				CH_UP_S: ps_cat = CAT_SYSTEM;
				CH_UP_O: ps_cat = CAT_OWNER;
				CH_UP_G: ps_cat = CAT_GROUP;
				default: ps_cat = CAT_WORLD;
			endcase
			ps_group = GROUP_MASK;
			ps_phase = PH_CAT;
		end else begin
			ps_phase = PH_SKIP;
		end
	endtask

	// A byte of an access list: listed letters clear their deny bit, a list end folds the
	// group into the word, and unknown bytes (a tab among them) are ignored.
	task automatic access_list(input logic [7:0] c);
		logic [7:0] u;
		u = fold_case(c);
		if (c == CH_NUL || c == CH_COMMA || c == CH_RPAREN || c == CH_SPACE) begin
			ps_word = word_with_group();
			ps_phase = (c == CH_NUL || c == CH_RPAREN) ? PH_DONE : PH_SEP;
			return;
		end
		case (u)
			CH_UP_R: ps_group[ACC_READ] = 1'b0;
			CH_UP_W: ps_group[ACC_WRITE] = 1'b0;
			CH_UP_E: ps_group[ACC_EXEC] = 1'b0;
			CH_UP_D: ps_group[ACC_DELETE] = 1'b0;
			default: ;
		endcase
		ps_phase = PH_ACCESS;
	endtask

	// Advances the parse by one accepted request and gives the word it emits, if any.
	task automatic parse_request(input req_t r, output bit emits, output logic [15:0] word);
		if (r.f) begin
			ps_phase = PH_START;
			ps_word = r.base;
			ps_group = GROUP_MASK;
			ps_cat = CAT_SYSTEM;
		end
		case (ps_phase)
			PH_START: begin
				ps_phase = PH_SEP;
				if (r.ch != CH_LPAREN) begin
					between_cats(r.ch);
				end
			end
			PH_SEP: between_cats(r.ch);
			PH_CAT: begin
				if (r.ch == CH_COLON) begin
					ps_phase = PH_ACCESS;
				end else begin
					access_list(r.ch);
				end
			end
			PH_ACCESS: access_list(r.ch);
			PH_SKIP: begin
				if (r.ch == CH_NUL || r.ch == CH_RPAREN) begin
					ps_phase = PH_DONE;
				end else if (r.ch == CH_COMMA) begin
					ps_phase = PH_SEP;
				end
			end
			default: ps_phase = PH_DONE;
		endcase
		emits = r.l;
		word = (ps_phase == PH_CAT || ps_phase == PH_ACCESS) ? word_with_group() : ps_word;
	endtask

	// Presents one request and holds it until the handshake. Before it, the sender may go
	// quiet for a burst of cycles, with the payload scrambled while valid is low. The
	// handshake is sampled right after the edge, so in_ready is the value it had there.
	task automatic send_request(input req_t r, input bit typed, input logic [15:0] want);
		bit emits;
		logic [15:0] word;
		if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			first <= 1'($urandom_range(0, 1));
			base_prot <= 16'($urandom_range(0, 16'hFFFF));
			char_code <= 8'($urandom_range(0, 8'hFF));
			last <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		first <= r.f;
		base_prot <= r.base;
		char_code <= r.ch;
		last <= r.l;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent_cnt++;
		parse_request(r, emits, word);
		if (emits) begin
			expected_words.push_back(typed ? want : word);
		end
	endtask

	// Waits until every expected result has been checked, always stepping past a clock edge first.
	task automatic drain_results();
		@(posedge clk);
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] cat_letter();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = CH_UP_S;
			1: c = CH_UP_O;
			2: c = CH_UP_G;
			default: c = CH_UP_W;
		endcase
		return $urandom_range(0, 1) ? (c | CASE_DIFF) : c;
	endfunction

	// Half the time any byte at all, otherwise one of the bytes the parser reacts to.
	function automatic logic [7:0] noise_char();
		if ($urandom_range(0, 1) == 0) begin
			return 8'($urandom_range(0, 8'hFF));
		end
		case ($urandom_range(0, 7))
			0: return CH_NUL;
			1: return CH_TAB;
			2: return CH_SPACE;
			3: return CH_LPAREN;
			4: return CH_RPAREN;
			5: return CH_COMMA;
			6: return CH_COLON;
			default: return cat_letter();
		endcase
	endfunction

	function automatic logic [7:0] access_letter();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: c = CH_UP_R;
			2, 3: c = CH_UP_W;
			4, 5: c = CH_UP_E;
			6, 7: c = CH_UP_D;
			8: return $urandom_range(0, 1) ? CH_TAB : CH_COLON;
			default: c = 8'($urandom_range(8'h41, 8'h5A));
		endcase
		return $urandom_range(0, 1) ? (c | CASE_DIFF) : c;
	endfunction

	// Builds one text into text_q. Most texts are well-formed protection strings with
	// random categories, cases, colons and access letters; the rest are plain noise.
	task automatic compose_text();
		int ncat;
		text_q.delete();
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 2) != 0) begin
				text_q.push_back(CH_LPAREN);
			end
			ncat = $urandom_range(0, 4);
			for (int i = 0; i < ncat; i++) begin
				if (i > 0) begin
					text_q.push_back($urandom_range(0, 4) == 0 ? CH_SPACE : CH_COMMA);
				end
				repeat ($urandom_range(0, 1)) begin
					text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				end
				if ($urandom_range(0, 9) == 0) begin
					// Unknown category word; a skip runs until the next comma.
					repeat ($urandom_range(1, 4)) text_q.push_back(noise_char());
				end else begin
					text_q.push_back(cat_letter());
					if ($urandom_range(0, 3) != 0) begin
						text_q.push_back(CH_COLON);
					end
					repeat ($urandom_range(0, 5)) text_q.push_back(access_letter());
				end
			end
			case ($urandom_range(0, 3))
				0: text_q.push_back(CH_RPAREN);
				1: text_q.push_back(CH_NUL);
				2: begin
					// Bytes after the close must be ignored.
					text_q.push_back(CH_RPAREN);
					repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
				end
				default: ;
			endcase
		end else begin
			repeat ($urandom_range(1, 8)) text_q.push_back(noise_char());
		end
		if (text_q.size() == 0) begin
			text_q.push_back(CH_NUL);
		end
	endtask

	// Stimulus: reset, the directed table, then random texts up to the item count. The
	// sender drains all results once after the table and once mid-run, and the last
	// stretch runs with no idling on either side.
	initial begin
		req_t r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			r.f = DIR_TAB[i].f;
			r.base = DIR_TAB[i].base;
			r.ch = DIR_TAB[i].ch;
			r.l = DIR_TAB[i].l;
			send_request(r, DIR_TAB[i].typed, DIR_TAB[i].want);
		end
		in_valid <= 1'b0;
		drain_results();

		while (sent_cnt < ITEM_TARGET) begin
			compose_text();
			for (int k = 0; k < text_q.size(); k++) begin
				// Now and then a text starts without its first flag and continues the
				// previous parse, and last may fall in the middle or be left off.
				r.f = (k == 0) && ($urandom_range(0, 15) != 0);
				case ($urandom_range(0, 5))
					0: r.base = 16'h0000;
					1: r.base = 16'hFFFF;
					default: r.base = 16'($urandom_range(0, 16'hFFFF));
				endcase
				r.ch = text_q[k];
				if (k == text_q.size() - 1) begin
					r.l = ($urandom_range(0, 19) != 0);
				end else begin
					r.l = ($urandom_range(0, 24) == 0);
				end
				send_request(r, 1'b0, 16'h0000);
			end
			if (sent_cnt >= PAUSE_AT && sent_cnt - text_q.size() < PAUSE_AT) begin
				in_valid <= 1'b0;
				drain_results();
			end
			quiet_mode = (sent_cnt >= QUIET_AT);
		end
		in_valid <= 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (err_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result side: checks each accepted word against the oldest expected one, then picks
	// out_ready for the next cycle, stalling in random bursts outside the quiet stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result: expected none, actual %h",
						$time, prot_word);
				end else begin
					if (prot_word !== expected_words[0]) begin
						err_cnt++;
						$display("%0t: prot_word mismatch: expected %h, actual %h",
							$time, expected_words[0], prot_word);
					end
					void'(expected_words.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog, well beyond the slowest correct run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcp_pkg.sv
rtl/protection_code_parser_top.sv
tb/tb_protection_code_parser_top.sv
